@@ src/lft_pkg.sv @@
// ----------------------------------------------------------------------------
// lft_pkg
// shared types, codes, character constants and a whitespace helper of the logfmt line tokenizer
// ----------------------------------------------------------------------------
package lft_pkg;

    typedef enum logic [2:0] {
        MODE_SKIP   = 3'd0,
        MODE_KEY    = 3'd1,
        MODE_VSTART = 3'd2,
        MODE_PLAIN  = 3'd3,
        MODE_QUOTED = 3'd4,
        MODE_ESCAPE = 3'd5,
        MODE_AFTERQ = 3'd6
    } t_mode;

    localparam logic [2:0] KIND_KEY   = 3'd0;
    localparam logic [2:0] KIND_VAL   = 3'd1;
    localparam logic [2:0] KIND_PAIR  = 3'd2;
    localparam logic [2:0] KIND_OK    = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;
    localparam logic [2:0] KIND_BLANK = 3'd5;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_EMPTY_KEY    = 3'd1;
    localparam logic [2:0] ERR_NO_EQUALS    = 3'd2;
    localparam logic [2:0] ERR_ESCAPE       = 3'd3;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd4;
    localparam logic [2:0] ERR_JUNK         = 3'd5;

    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    typedef struct packed {
        t_mode      mode;
        logic       pair_seen;
        logic [2:0] line_error;
    } t_state;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic [2:0] err;
        logic       last;
    } t_result;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

@@ src/lft_step.sv @@
// ----------------------------------------------------------------------------
// lft_step
// next-state and result decode for one byte or line end
// ----------------------------------------------------------------------------
module lft_step
    import lft_pkg::*;
(
    input  logic [7:0] i_char,
    input  logic       i_line_end,
    input  t_state     i_state,
    output t_state     o_state,
    output logic [1:0] o_count,
    output t_result    o_res0,
    output t_result    o_res1
);

    always_comb begin
        o_state = i_state;
        o_count = 2'd0;
        o_res0  = '0;
        o_res1  = '0;

        if (i_line_end) begin
            o_count = 2'd1;
            if (i_state.line_error != ERR_NONE) begin
                o_res0.kind = KIND_ERR;
                o_res0.err  = i_state.line_error;
            end else begin
                unique case (i_state.mode)
                    MODE_KEY: begin
                        o_res0.kind = KIND_ERR;
                        o_res0.err  = ERR_NO_EQUALS;
                    end
                    MODE_VSTART, MODE_PLAIN, MODE_AFTERQ: begin
                        o_count     = 2'd2;
                        o_res0.kind = KIND_PAIR;
                        o_res1.kind = KIND_OK;
                    end
                    MODE_QUOTED: begin
                        o_res0.kind = KIND_ERR;
                        o_res0.err  = ERR_UNTERMINATED;
                    end
                    MODE_ESCAPE: begin
                        o_res0.kind = KIND_ERR;
                        o_res0.err  = ERR_ESCAPE;
                    end
                    default: begin
                        o_res0.kind = i_state.pair_seen ? KIND_OK : KIND_BLANK;
                    end
                endcase
            end
            o_state = '{mode: MODE_SKIP, pair_seen: 1'b0, line_error: ERR_NONE};
        end else if (i_state.line_error == ERR_NONE) begin
            unique case (i_state.mode)
                MODE_KEY: begin
                    if (i_char == CH_EQUALS) begin
                        o_state.mode = MODE_VSTART;
                    end else if (is_ws(i_char)) begin
                        o_state.line_error = ERR_NO_EQUALS;
                    end else begin
                        o_count     = 2'd1;
                        o_res0.kind = KIND_KEY;
                        o_res0.ch   = i_char;
                    end
                end
                MODE_VSTART: begin
                    if (i_char == CH_QUOTE) begin
                        o_state.mode = MODE_QUOTED;
                    end else if (is_ws(i_char)) begin
                        o_count           = 2'd1;
                        o_res0.kind       = KIND_PAIR;
                        o_state.pair_seen = 1'b1;
                        o_state.mode      = MODE_SKIP;
                    end else begin
                        o_count      = 2'd1;
                        o_res0.kind  = KIND_VAL;
                        o_res0.ch    = i_char;
                        o_state.mode = MODE_PLAIN;
                    end
                end
                MODE_PLAIN: begin
                    o_count = 2'd1;
                    if (is_ws(i_char)) begin
                        o_res0.kind       = KIND_PAIR;
                        o_state.pair_seen = 1'b1;
                        o_state.mode      = MODE_SKIP;
                    end else begin
                        o_res0.kind = KIND_VAL;
                        o_res0.ch   = i_char;
                    end
                end
                MODE_QUOTED: begin
                    if (i_char == CH_QUOTE) begin
                        o_state.mode = MODE_AFTERQ;
                    end else if (i_char == CH_BSLASH) begin
                        o_state.mode = MODE_ESCAPE;
                    end else begin
                        o_count     = 2'd1;
                        o_res0.kind = KIND_VAL;
                        o_res0.ch   = i_char;
                    end
                end
                MODE_ESCAPE: begin
                    o_count      = 2'd1;
                    o_res0.kind  = KIND_VAL;
                    o_state.mode = MODE_QUOTED;
                    priority if (i_char == CH_QUOTE || i_char == CH_BSLASH) begin
                        o_res0.ch = i_char;
                    end else if (i_char == CH_LOW_N) begin
                        o_res0.ch = CH_LF;
                    end else if (i_char == CH_LOW_R) begin
                        o_res0.ch = CH_CR;
                    end else if (i_char == CH_LOW_T) begin
                        o_res0.ch = CH_TAB;
                    end else begin
                        o_count     = 2'd2;
                        o_res0.ch   = CH_BSLASH;
                        o_res1.kind = KIND_VAL;
                        o_res1.ch   = i_char;
                    end
                end
                MODE_AFTERQ: begin
                    if (is_ws(i_char)) begin
                        o_count           = 2'd1;
                        o_res0.kind       = KIND_PAIR;
                        o_state.pair_seen = 1'b1;
                        o_state.mode      = MODE_SKIP;
                    end else begin
                        o_state.line_error = ERR_JUNK;
                    end
                end
                default: begin
                    if (is_ws(i_char)) begin
                        o_state.mode = MODE_SKIP;
                    end else if (i_char == CH_EQUALS) begin
                        o_state.line_error = ERR_EMPTY_KEY;
                    end else begin
                        o_count      = 2'd1;
                        o_res0.kind  = KIND_KEY;
                        o_res0.ch    = i_char;
                        o_state.mode = MODE_KEY;
                    end
                end
            endcase
        end

        o_res0.last = (o_count == 2'd1);
        o_res1.last = (o_count == 2'd2);
    end

endmodule

@@ src/lft_outq.sv @@
// ----------------------------------------------------------------------------
// lft_outq
// two-entry result queue, head entry drives the output port
// ----------------------------------------------------------------------------
module lft_outq
    import lft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_count,
    input  t_result    i_word0,
    input  t_result    i_word1,
    input  logic       i_stall,
    output logic [1:0] o_free,
    output logic       o_valid,
    output t_result    o_head
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_result    r_q0;
    t_result    r_q1;
    t_result    n_q0;
    t_result    n_q1;
    logic       pop;
    logic [1:0] cnt_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q0;
    assign pop     = o_valid && !i_stall;
    assign o_free  = 2'd2 - r_cnt + {1'b0, pop};

    always_comb begin
        n_q0    = r_q0;
        n_q1    = r_q1;
        cnt_pop = r_cnt;
        if (pop) begin
            n_q0    = r_q1;
            cnt_pop = r_cnt - 2'd1;
        end
        if (i_push_count != 2'd0) begin
            if (cnt_pop == 2'd0) begin
                n_q0 = i_word0;
                if (i_push_count == 2'd2) begin
                    n_q1 = i_word1;
                end
            end else begin
                n_q1 = i_word0;
            end
        end
        n_cnt = cnt_pop + i_push_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_count <= o_free)
        else $error("result queue overflow");
`endif

endmodule

@@ src/logfmt_line_tokenizer.sv @@
// ----------------------------------------------------------------------------
// logfmt_line_tokenizer
// Streams a logfmt line one byte per word and returns key characters, value
// characters, pair ends and a line status at each line-end word. A byte is
// taken every cycle while o_stall is low; it passes an input register, is
// decoded in one step and lands in a two-entry result queue. The single result
// port delivers one word per cycle while i_stall is low, so each byte that
// yields two results (an unknown escape, or a line end that ends a value) takes
// an extra output slot, and input stalls once the queue has filled.
// ----------------------------------------------------------------------------
module logfmt_line_tokenizer
    import lft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_line_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_kind,
    output logic [7:0] o_out_char,
    output logic [2:0] o_error_code,
    output logic       o_last_result
);

    logic       r_in_vld;
    logic [7:0] r_in_char;
    logic       r_in_eol;
    t_state     r_state;
    t_state     step_state;
    logic [1:0] step_count;
    t_result    step_res0;
    t_result    step_res1;
    logic [1:0] q_free;
    logic [1:0] push_count;
    logic       adv;
    logic       accept;
    t_result    head;

    lft_step u_step (
        .i_char     (r_in_char),
        .i_line_end (r_in_eol),
        .i_state    (r_state),
        .o_state    (step_state),
        .o_count    (step_count),
        .o_res0     (step_res0),
        .o_res1     (step_res1)
    );

    assign adv        = r_in_vld && (step_count <= q_free);
    assign push_count = adv ? step_count : 2'd0;
    assign o_stall    = r_in_vld && !adv;
    assign accept     = i_valid && !o_stall;

    lft_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_word0      (step_res0),
        .i_word1      (step_res1),
        .i_stall      (i_stall),
        .o_free       (q_free),
        .o_valid      (o_valid),
        .o_head       (head)
    );

    assign o_kind        = head.kind;
    assign o_out_char    = head.ch;
    assign o_error_code  = head.err;
    assign o_last_result = head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_state  <= '{mode: MODE_SKIP, pair_seen: 1'b0, line_error: ERR_NONE};
        end else begin
            if (accept) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_state <= step_state;
            end
        end
        if (accept) begin
            r_in_char <= i_char_code;
            r_in_eol  <= i_line_end;
        end
    end

`ifndef ASSERT_OFF
    a_line_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_eol |=> r_state.mode == MODE_SKIP && !r_state.pair_seen
            && r_state.line_error == ERR_NONE)
        else $error("state not cleared after line end");

    a_err_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_ERR |-> o_error_code != ERR_NONE)
        else $error("line error without code");

    a_status_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_PAIR || o_kind == KIND_OK || o_kind == KIND_BLANK)
            |-> o_out_char == 8'd0 && o_error_code == ERR_NONE)
        else $error("status word carries payload");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_OK || o_kind == KIND_ERR || o_kind == KIND_BLANK)
            |-> o_last_result)
        else $error("line status not marked last");
`endif

endmodule
